>>> hdl/knap_pkg.sv
package knap_pkg;

    localparam int MAX_ITEMS_DEF    = 32;
    localparam int MAX_CAPACITY_DEF = 1023;
    localparam int VALUE_BITS_DEF   = 16;

    localparam int VALUE_W   = 16;
    localparam int WEIGHT_W  = 10;
    localparam int TAG_W     = 5;
    localparam int CAP_REG_W = 10;
    localparam int CELL_W    = 21;
    localparam int USED_W    = 10;
    localparam int TAG_COUNT = 1 << TAG_W;

    localparam logic [CELL_W-1:0] CELL_MAX = '1;

    localparam logic KIND_TAG     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0]  item_value;
        logic [WEIGHT_W-1:0] item_weight;
        logic [TAG_W-1:0]    item_tag;
        logic                last_item;
    } item_t;

    typedef struct packed {
        logic                result_kind;
        logic [TAG_W-1:0]    chosen_tag;
        logic [CELL_W-1:0]   total_value;
        logic [USED_W-1:0]   used_weight;
        logic                last_result;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_FLUSH,
        S_TRACE_START,
        S_TRACE_TOTAL,
        S_TRACE_READ,
        S_TRACE_EVAL,
        S_EMIT,
        S_SUMMARY
    } state_t;

endpackage

>>> hdl/knapsack_01_dp_select.sv
// a stored item sweeps the row memory one best-value cell per cycle (read two cells, add,
// compare, write back); a new item is taken only once the sweep of the last one has drained;
// the last item then adds a traceback (take-bit memory read per step) and a scan over all
// TAG_COUNT tags, plus output stalls, before the summary item is out
// reset: control, counters and the capacity register clear; memories keep their contents,
// the best-value row is read as zero during the first item of every run, so no clearing pass
module knapsack_01_dp_select #(
    parameter int MAX_ITEMS    = knap_pkg::MAX_ITEMS_DEF,
    parameter int MAX_CAPACITY = knap_pkg::MAX_CAPACITY_DEF,
    parameter int VALUE_BITS   = knap_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [knap_pkg::CAP_REG_W-1:0]   cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  knap_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output knap_pkg::result_t                result
);
    import knap_pkg::*;

    localparam int CAP_BITS = $clog2(MAX_CAPACITY + 1);
    localparam int CW0      = (CAP_BITS > CAP_REG_W) ? CAP_BITS : CAP_REG_W;
    localparam int CW       = (CW0 > WEIGHT_W) ? CW0 : WEIGHT_W;
    localparam int IDX_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int VB       = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int TAKE_AW  = IDX_W + CAP_BITS;
    localparam int SUM_W    = CELL_W + 1;
    localparam int ENTRY_W  = TAG_W + WEIGHT_W;

    localparam logic [CAP_BITS-1:0] W_TOP = CAP_BITS'(MAX_CAPACITY);

    // memories
    logic [CELL_W-1:0]  row_mem  [1 << CAP_BITS];
    logic               take_mem [1 << TAKE_AW];
    logic [ENTRY_W-1:0] item_mem [1 << IDX_W];

    logic [CELL_W-1:0]  row_rd_a_reg;
    logic [CELL_W-1:0]  row_rd_b_reg;
    logic               take_rd_reg;
    logic [ENTRY_W-1:0] item_rd_reg;

    logic                row_we;
    logic [CAP_BITS-1:0] row_wa;
    logic [CELL_W-1:0]   row_wd;
    logic [CAP_BITS-1:0] row_ra_a;
    logic [CAP_BITS-1:0] row_ra_b;
    logic                take_we;
    logic [TAKE_AW-1:0]  take_wa;
    logic                take_wd;
    logic [TAKE_AW-1:0]  take_ra;
    logic                item_we;
    logic [IDX_W-1:0]    item_wa;
    logic [ENTRY_W-1:0]  item_wd;
    logic [IDX_W-1:0]    item_ra;

    // control and datapath registers
    state_t               state_reg, state_next;
    logic [CAP_REG_W-1:0] capacity_reg, capacity_next;
    logic [CNT_W-1:0]     loaded_reg, loaded_next;
    logic [VB-1:0]        val_reg, val_next;
    logic [WEIGHT_W-1:0]  wt_reg, wt_next;
    logic                 last_reg, last_next;
    logic                 first_reg, first_next;
    logic [CAP_BITS-1:0]  w_reg, w_next;
    logic                 p_valid_reg, p_valid_next;
    logic [CAP_BITS-1:0]  p_w_reg, p_w_next;
    logic                 p_fits_reg, p_fits_next;
    logic                 zero_a_reg, zero_a_next;
    logic                 zero_b_reg, zero_b_next;
    logic [CAP_BITS-1:0]  cap_reg, cap_next;
    logic [CAP_BITS-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [TAG_COUNT-1:0] mask_reg, mask_next;
    logic [TAG_W-1:0]     tag_idx_reg, tag_idx_next;
    logic [CELL_W-1:0]    total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic                 accept;
    logic                 room;
    logic [IDX_W-1:0]     k_idx;
    logic [CW-1:0]        w_ext;
    logic [CW-1:0]        wt_ext;
    logic                 fits;
    logic [CW-1:0]        diff;
    logic [CW-1:0]        cap_ext;
    logic [CAP_BITS-1:0]  cap_clamped;
    logic [CELL_W-1:0]    keep_val;
    logic [CELL_W-1:0]    src_val;
    logic [SUM_W-1:0]     sum;
    logic [CELL_W-1:0]    cand;
    logic                 take_bit;
    logic [CNT_W-1:0]     idx_m1;
    logic [WEIGHT_W-1:0]  rd_wt;
    logic [TAG_W-1:0]     rd_tag;
    logic [CW-1:0]        rem_sub;
    logic [CW-1:0]        used_ext;
    logic                 slot_free;
    logic                 out_load;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign accept    = item_valid && item_ready;
    assign room      = (loaded_reg < CNT_W'(MAX_ITEMS));
    assign k_idx     = loaded_reg[IDX_W-1:0];
    assign slot_free = !out_valid_reg || result_ready;

    // sweep address math
    assign w_ext  = CW'(w_reg);
    assign wt_ext = CW'(wt_reg);
    assign fits   = (wt_ext <= w_ext);
    assign diff   = w_ext - wt_ext;

    assign cap_ext     = CW'(capacity_reg);
    assign cap_clamped = (cap_ext > CW'(MAX_CAPACITY)) ? W_TOP : cap_ext[CAP_BITS-1:0];

    // write-back stage: cells of the first item of a run and cell 0 read as zero
    assign keep_val = zero_a_reg ? '0 : row_rd_a_reg;
    assign src_val  = zero_b_reg ? '0 : row_rd_b_reg;
    assign sum      = SUM_W'(val_reg) + SUM_W'(src_val);
    assign cand     = sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0];
    assign take_bit = p_fits_reg && (cand > keep_val);

    assign row_we  = p_valid_reg;
    assign row_wa  = p_w_reg;
    assign row_wd  = take_bit ? cand : keep_val;
    assign take_we = p_valid_reg;
    assign take_wa = {k_idx, p_w_reg};
    assign take_wd = take_bit;

    assign row_ra_a = (state_reg == S_SWEEP) ? w_reg : cap_reg;
    assign row_ra_b = fits ? diff[CAP_BITS-1:0] : '0;

    // traceback addressing
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign take_ra  = {idx_m1[IDX_W-1:0], rem_reg};
    assign item_ra  = idx_m1[IDX_W-1:0];
    assign rd_wt    = item_rd_reg[WEIGHT_W-1:0];
    assign rd_tag   = item_rd_reg[ENTRY_W-1:WEIGHT_W];
    assign rem_sub  = CW'(rem_reg) - CW'(rd_wt);
    assign used_ext = CW'(cap_reg) - CW'(rem_reg);

    assign item_we = accept && room;
    assign item_wa = k_idx;
    assign item_wd = {item.item_tag, item.item_weight};

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        row_rd_a_reg <= row_mem[row_ra_a];
        row_rd_b_reg <= row_mem[row_ra_b];
        if (take_we)
        begin
            take_mem[take_wa] <= take_wd;
        end
        take_rd_reg <= take_mem[take_ra];
        if (item_we)
        begin
            item_mem[item_wa] <= item_wd;
        end
        item_rd_reg <= item_mem[item_ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        capacity_next  = cfg_valid ? cfg_data : capacity_reg;
        loaded_next    = loaded_reg;
        val_next       = val_reg;
        wt_next        = wt_reg;
        last_next      = last_reg;
        first_next     = first_reg;
        w_next         = w_reg;
        p_valid_next   = (state_reg == S_SWEEP);
        p_w_next       = w_reg;
        p_fits_next    = fits;
        zero_a_next    = (state_reg == S_SWEEP) ? first_reg : (cap_reg == '0);
        zero_b_next    = first_reg || !fits || (diff == '0);
        cap_next       = cap_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        tag_idx_next   = tag_idx_reg;
        total_next     = total_reg;
        out_load       = 1'b0;
        out_next       = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = item.last_item;
                    if (item.last_item)
                    begin
                        cap_next = cap_clamped;
                    end
                    if (room)
                    begin
                        val_next   = item.item_value[VB-1:0];
                        wt_next    = item.item_weight;
                        first_next = (loaded_reg == '0);
                        w_next     = W_TOP;
                        state_next = S_SWEEP;
                    end
                    else if (item.last_item)
                    begin
                        state_next = S_TRACE_START;
                    end
                end
            end
            S_SWEEP:
            begin
                w_next = w_reg - CAP_BITS'(1);
                if (w_reg == CAP_BITS'(1))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // last cell is written this cycle
                loaded_next = loaded_reg + CNT_W'(1);
                state_next  = last_reg ? S_TRACE_START : S_IDLE;
            end
            S_TRACE_START:
            begin
                rem_next   = cap_reg;
                idx_next   = loaded_reg;
                mask_next  = '0;
                state_next = S_TRACE_TOTAL;
            end
            S_TRACE_TOTAL:
            begin
                total_next = keep_val;
                state_next = S_TRACE_READ;
            end
            S_TRACE_READ:
            begin
                if (idx_reg == '0 || rem_reg == '0)
                begin
                    tag_idx_next = '1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    state_next = S_TRACE_EVAL;
                end
            end
            S_TRACE_EVAL:
            begin
                if (take_rd_reg)
                begin
                    mask_next = mask_reg | (TAG_COUNT'(1) << rd_tag);
                    rem_next  = rem_sub[CAP_BITS-1:0];
                end
                idx_next   = idx_m1;
                state_next = S_TRACE_READ;
            end
            S_EMIT:
            begin
                if (!mask_reg[tag_idx_reg] || slot_free)
                begin
                    if (mask_reg[tag_idx_reg])
                    begin
                        out_load             = 1'b1;
                        out_next.result_kind = KIND_TAG;
                        out_next.chosen_tag  = tag_idx_reg;
                        out_next.total_value = '0;
                        out_next.used_weight = '0;
                        out_next.last_result = 1'b0;
                    end
                    if (tag_idx_reg == '0)
                    begin
                        state_next = S_SUMMARY;
                    end
                    else
                    begin
                        tag_idx_next = tag_idx_reg - TAG_W'(1);
                    end
                end
            end
            S_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_load             = 1'b1;
                    out_next.result_kind = KIND_SUMMARY;
                    out_next.chosen_tag  = '0;
                    out_next.total_value = total_reg;
                    out_next.used_weight = USED_W'(used_ext);
                    out_next.last_result = 1'b1;
                    loaded_next          = '0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= '0;
            loaded_reg    <= '0;
            val_reg       <= '0;
            wt_reg        <= '0;
            last_reg      <= 1'b0;
            first_reg     <= 1'b0;
            w_reg         <= '0;
            p_valid_reg   <= 1'b0;
            p_w_reg       <= '0;
            p_fits_reg    <= 1'b0;
            zero_a_reg    <= 1'b1;
            zero_b_reg    <= 1'b1;
            cap_reg       <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            mask_reg      <= '0;
            tag_idx_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            loaded_reg    <= loaded_next;
            val_reg       <= val_next;
            wt_reg        <= wt_next;
            last_reg      <= last_next;
            first_reg     <= first_next;
            w_reg         <= w_next;
            p_valid_reg   <= p_valid_next;
            p_w_reg       <= p_w_next;
            p_fits_reg    <= p_fits_next;
            zero_a_reg    <= zero_a_next;
            zero_b_reg    <= zero_b_next;
            cap_reg       <= cap_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            tag_idx_reg   <= tag_idx_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // the row write-back stage is drained before a new item can start a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !p_valid_reg)
        else $error("row write pending while idle");

    // cell 0 is never written; it is read as zero instead
    assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (row_wa != '0))
        else $error("write to capacity zero cell");

    // a taken item always fits in what is left during traceback
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRACE_EVAL && take_rd_reg) |-> (CW'(rd_wt) <= CW'(rem_reg)))
        else $error("traceback weight exceeds remaining capacity");

    // a new result item is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result_ready))
        else $error("result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count overflow");

endmodule
